// ----- rtl/kmd_pkg.sv -----
// Shared types, constants and codes for the key matrix debouncer.
// Used by every module under rtl except kmd_ram; depends on nothing.
package kmd_pkg;

  // Matrix geometry
  localparam int ROWS  = 8;
  localparam int COLS  = 32;
  localparam int NKEYS = ROWS * COLS;
  localparam int IDX_W = (NKEYS > 1) ? $clog2(NKEYS) : 1;

  // Field widths
  localparam int ROW_W = 3;
  localparam int COL_W = 5;
  localparam int EVT_W = 2;
  localparam int THR_W = 6;
  localparam int CNT_W = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = THR_W;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 1'b1;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = 6'd5;

  typedef enum logic [EVT_W-1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2,
    EV_HELD    = 2'd3
  } key_event_t;

  // One stored entry per key: last raw bit and signed settle counter
  typedef struct packed {
    logic                    raw;
    logic signed [CNT_W-1:0] cnt;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam entry_t ENTRY_RESET = '{raw: 1'b0, cnt: '1};

endpackage

// ----- rtl/kmd_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; no package needed.
module kmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/kmd_update.sv -----
// Per-key debounce update: next entry and event code from one stored entry.
// Depends on kmd_pkg.
module kmd_update (
  input  kmd_pkg::entry_t                  cur_entry,
  input  logic                             raw_pressed,
  input  logic [kmd_pkg::THR_W-1:0]        threshold,
  input  logic                             report_mode,
  output kmd_pkg::entry_t                  new_entry,
  output kmd_pkg::key_event_t              key_event
);
  import kmd_pkg::*;

  logic                    cnt_ge_thr;
  logic signed [CNT_W-1:0] evt_cnt;

  // Signed counter against the non-negative threshold
  assign cnt_ge_thr = $signed({cur_entry.cnt[CNT_W-1], cur_entry.cnt})
                      >= $signed({3'b000, threshold});

  // Edge restarts the count in event mode
  assign evt_cnt = (cur_entry.raw != raw_pressed) ? '0 : cur_entry.cnt;

  always_comb begin
    new_entry.raw = raw_pressed;
    new_entry.cnt = cur_entry.cnt;
    key_event     = EV_NONE;
    if (report_mode) begin
      if (raw_pressed) begin
        if (cnt_ge_thr) begin
          key_event     = EV_HELD;
          new_entry.cnt = $signed({1'b0, threshold, 1'b0});
        end else begin
          new_entry.cnt = cur_entry.cnt + 8'sd1;
        end
      end else begin
        if (cnt_ge_thr) begin
          key_event     = EV_HELD;
          new_entry.cnt = cur_entry.cnt - 8'sd1;
        end else begin
          new_entry.cnt = '0;
        end
      end
    end else begin
      new_entry.cnt = evt_cnt;
      if (!evt_cnt[CNT_W-1]) begin
        if (evt_cnt[CNT_W-2:0] >= {1'b0, threshold}) begin
          key_event     = raw_pressed ? EV_PRESS : EV_RELEASE;
          new_entry.cnt = '1;
        end else begin
          new_entry.cnt = evt_cnt + 8'sd1;
        end
      end
    end
  end

endmodule

// ----- rtl/key_matrix_debouncer_unit.sv -----
// Key matrix debouncer: per-key raw bit and settle counter held in one RAM.
// Beats pass stage 1, then the output register; one beat per cycle unless stalled,
// set by the single read-modify-write of the state RAM (read, then update+write).
// Reset (synchronous) clears the per-key valid flags at once, so every key reads
// as raw 0 / counter -1 until first written; no clearing pass. Threshold resets
// to 5 and the mode to event mode.
module key_matrix_debouncer_unit (
  input  logic                              clk,
  input  logic                              rst,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [kmd_pkg::ROW_W-1:0]         key_row,
  input  logic [kmd_pkg::COL_W-1:0]         key_col,
  input  logic                              raw_pressed,
  // Output channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [kmd_pkg::ROW_W-1:0]         out_row,
  output logic [kmd_pkg::COL_W-1:0]         out_col,
  output logic [kmd_pkg::EVT_W-1:0]         key_event,
  // Configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kmd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kmd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import kmd_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are always taken.
  // ---------------------------------------------------------------------------
  logic [THR_W-1:0] threshold;
  logic             report_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold   <= THRESHOLD_RESET;
      report_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_THRESHOLD: threshold   <= cfg_data[THR_W-1:0];
        REG_MODE:      report_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: key index and range check; launch the RAM read on accept.
  // ---------------------------------------------------------------------------
  localparam int LIN_W = IDX_W + 6;

  logic [LIN_W-1:0] lin_idx;
  logic [IDX_W-1:0] in_idx;
  logic             in_range;
  logic             in_fire;

  assign lin_idx  = LIN_W'(key_row) * LIN_W'(COLS) + LIN_W'(key_col);
  assign in_idx   = lin_idx[IDX_W-1:0];
  assign in_range = ({3'b000, key_row} < 6'(ROWS)) && ({1'b0, key_col} < 6'(COLS));
  assign in_fire  = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Stage 1: read data back, resolve hazards, update, write back.
  // ---------------------------------------------------------------------------
  logic             s1_valid;
  logic [IDX_W-1:0] s1_idx;
  logic             s1_range;
  logic [ROW_W-1:0] s1_row;
  logic [COL_W-1:0] s1_col;
  logic             s1_raw;
  logic             s1_adv;
  logic             s1_wr;

  // Output register frees when empty or when the sink takes the beat
  assign s1_adv   = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_adv;
  assign s1_wr    = s1_valid && s1_adv && s1_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_idx   <= in_idx;
      s1_range <= in_range;
      s1_row   <= key_row;
      s1_col   <= key_col;
      s1_raw   <= raw_pressed;
    end
  end

  // State RAM: one entry per key, read on accept, written when stage 1 retires
  entry_t           ram_rdata;
  entry_t           new_entry;
  logic [ENTRY_W-1:0] ram_rdata_bits;

  kmd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NKEYS)
  ) u_state_ram (
    .clk   (clk),
    .we    (s1_wr),
    .waddr (s1_idx),
    .wdata (new_entry),
    .re    (in_fire),
    .raddr (in_idx),
    .rdata (ram_rdata_bits)
  );

  assign ram_rdata = entry_t'(ram_rdata_bits);

  // Per-key written flags: an unwritten key reads as the reset entry
  logic [NKEYS-1:0] key_written;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_written <= '0;
    end else if (s1_wr) begin
      key_written[s1_idx] <= 1'b1;
    end
  end

  // Last write, kept to forward over a read that raced it on the same edge
  logic             fwd_valid;
  logic [IDX_W-1:0] fwd_idx;
  entry_t           fwd_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (s1_wr) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_wr) begin
      fwd_idx   <= s1_idx;
      fwd_entry <= new_entry;
    end
  end

  logic   fwd_hit;
  entry_t cur_entry;

  assign fwd_hit = fwd_valid && (fwd_idx == s1_idx);

  always_comb begin
    if (fwd_hit) begin
      cur_entry = fwd_entry;
    end else if (key_written[s1_idx]) begin
      cur_entry = ram_rdata;
    end else begin
      cur_entry = ENTRY_RESET;
    end
  end

  key_event_t upd_event;

  kmd_update u_update (
    .cur_entry   (cur_entry),
    .raw_pressed (s1_raw),
    .threshold   (threshold),
    .report_mode (report_mode),
    .new_entry   (new_entry),
    .key_event   (upd_event)
  );

  // ---------------------------------------------------------------------------
  // Output register: hold the beat until the sink takes it.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      out_row   <= s1_row;
      out_col   <= s1_col;
      // Keys outside the matrix touch no state and report nothing
      key_event <= s1_range ? upd_event : EV_NONE;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_written_clear: assert property (@(posedge clk)
    rst |=> (key_written == '0))
    else $error("written flags not cleared by reset");

  a_report_codes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && report_mode) |-> (key_event == EV_NONE || key_event == EV_HELD))
    else $error("event-mode code in report mode");

  a_event_codes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !report_mode) |-> (key_event != EV_HELD))
    else $error("held code in event mode");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_idx) && !s1_wr || s1_valid))
    else $error("stage 1 lost a stalled item");

  a_no_write_stalled: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |-> !s1_wr)
    else $error("state written while output stalled");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// Testbench for key_matrix_debouncer_unit: a per-key debounce predictor in a small
// scoreboard class checks every output beat. Depends on rtl/kmd_pkg.sv and the RTL.

module testbench;
  import kmd_pkg::*;

  // One expected output beat
  typedef struct {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    key_event_t       evt;
  } key_result_t;

  // Per-key debounce predictor and the queue of results it owes
  class debounce_board;
    logic                    last_raw [NKEYS];
    logic signed [CNT_W-1:0] settle   [NKEYS];
    logic [THR_W-1:0]        threshold;
    logic                    report_mode;
    key_result_t             expected_q [$];
    int                      mismatches;
    int                      checked;
    int                      ev_counts [4];

    function new();
      for (int k = 0; k < NKEYS; k++) begin
        last_raw[k] = 1'b0;
        settle[k]   = '1;
      end
      foreach (ev_counts[i]) ev_counts[i] = 0;
      threshold   = THRESHOLD_RESET;
      report_mode = 1'b0;
      mismatches  = 0;
      checked     = 0;
    endfunction

    task report_mismatch(string msg);
      if (mismatches < 40) $display("tb: mismatch at %0t: %s", $time, msg);
      mismatches++;
    endtask

    // Advance the predicted state of one key by one scan and queue its result
    function void note_key(logic [ROW_W-1:0] row, logic [COL_W-1:0] col, logic raw);
      key_result_t             r;
      int                      k;
      logic signed [CNT_W-1:0] cnt;
      logic signed [CNT_W-1:0] thr;
      r.row = row;
      r.col = col;
      r.evt = EV_NONE;
      if (int'(row) < ROWS && int'(col) < COLS) begin
        k   = int'(row) * COLS + int'(col);
        cnt = settle[k];
        thr = $signed({{(CNT_W-THR_W){1'b0}}, threshold});
        if (report_mode) begin
          if (raw) begin
            if (cnt >= thr) begin
              r.evt = EV_HELD;
              cnt   = thr + thr;
            end else begin
              cnt = cnt + 1;
            end
          end else begin
            if (cnt >= thr) begin
              r.evt = EV_HELD;
              cnt   = cnt - 1;
            end else begin
              cnt = 0;
            end
          end
        end else begin
          if (last_raw[k] != raw) cnt = 0;
          if (cnt >= 0) begin
            if (cnt >= thr) begin
              r.evt = raw ? EV_PRESS : EV_RELEASE;
              cnt   = -1;
            end else begin
              cnt = cnt + 1;
            end
          end
        end
        last_raw[k] = raw;
        settle[k]   = cnt;
      end
      expected_q.push_back(r);
    endfunction

    task check_result(logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                      logic [EVT_W-1:0] evt);
      key_result_t e;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("beat with nothing expected: row %0d col %0d event %0d",
                                  row, col, evt));
        return;
      end
      e = expected_q.pop_front();
      checked++;
      ev_counts[int'(e.evt)]++;
      if (row !== e.row)
        report_mismatch($sformatf("out_row %0d, expected %0d", row, e.row));
      if (col !== e.col)
        report_mismatch($sformatf("out_col %0d, expected %0d", col, e.col));
      if (evt !== e.evt)
        report_mismatch($sformatf("key_event %0d, expected %s at row %0d col %0d",
                                  evt, e.evt.name(), e.row, e.col));
    endtask

    task flush_leftovers();
      key_result_t e;
      while (expected_q.size() != 0) begin
        e = expected_q.pop_front();
        report_mismatch($sformatf("no beat for row %0d col %0d (%s)",
                                  e.row, e.col, e.evt.name()));
      end
    endtask
  endclass

  // Clock, reset and every block input start at known values
  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  logic [ROW_W-1:0]      key_row     = '0;
  logic [COL_W-1:0]      key_col     = '0;
  logic                  raw_pressed = 1'b0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  logic [ROW_W-1:0]      out_row;
  logic [COL_W-1:0]      out_col;
  logic [EVT_W-1:0]      key_event;
  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;

  debounce_board board;

  // Idle controls shared by the sender and the receiver; odds 0 means no idling
  int gap_odds     = 0;
  int stall_odds   = 0;
  bit hold_request = 1'b0;
  int settings     = 1;

  // Keys that the well-formed sequences keep returning to; the last is picked anew each phase
  logic [ROW_W-1:0] pool_row [3];
  logic [COL_W-1:0] pool_col [3];

  key_matrix_debouncer_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .key_row     (key_row),
    .key_col     (key_col),
    .raw_pressed (raw_pressed),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_row     (out_row),
    .out_col     (out_col),
    .key_event   (key_event),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Offer one key scan, maybe after a random idle burst, and hold it until the
  // block takes the beat. Valid stays high afterwards so back-to-back beats
  // need no second assignment in one step; the caller drops it when done.
  task automatic send_key(logic [ROW_W-1:0] row, logic [COL_W-1:0] col, logic raw);
    int gap;
    gap = 0;
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) gap = $urandom_range(1, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    key_row     <= row;
    key_col     <= col;
    raw_pressed <= raw;
    do @(posedge clk); while (!in_ready);
    board.note_key(row, col, raw);
  endtask

  // Scan a key somewhere in the matrix with a random contact state
  task automatic send_stray();
    send_key(ROW_W'($urandom_range(0, ROWS - 1)), COL_W'($urandom_range(0, COLS - 1)),
             1'($urandom_range(0, 1)));
  endtask

  // Write threshold then mode as two beats; valid stays up between them
  task automatic configure(logic [THR_W-1:0] thr, logic mode);
    cfg_valid <= 1'b1;
    cfg_index <= REG_THRESHOLD;
    cfg_data  <= CFG_DATA_W'(thr);
    do @(posedge clk); while (!cfg_ready);
    board.threshold = thr;
    cfg_index <= REG_MODE;
    cfg_data  <= CFG_DATA_W'(mode);
    do @(posedge clk); while (!cfg_ready);
    board.report_mode = mode;
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // Hold until every queued result has come back
  task automatic wait_drained();
    while (board.expected_q.size() != 0) @(posedge clk);
  endtask

  // Random traffic: mostly a pool key held at one level, often long enough to settle,
  // with stray keys mixed in, plus contact bounce and lone strays.
  task automatic run_phase(int n_items);
    int   sent;
    int   run_len;
    int   pick;
    int   thr;
    logic level;
    sent = 0;
    thr  = int'(board.threshold);
    pool_row[2] = ROW_W'($urandom_range(0, ROWS - 1));
    pool_col[2] = COL_W'($urandom_range(0, COLS - 1));
    while (sent < n_items) begin
      pick  = $urandom_range(0, 2);
      level = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0, 1: begin
          // bounce: flip the contact every scan
          repeat ($urandom_range(1, 4)) begin
            send_key(pool_row[pick], pool_col[pick], level);
            level = ~level;
            sent++;
          end
        end
        2: begin
          send_stray();
          sent++;
        end
        default: begin
          // steady level, often just past the threshold so events fire
          if ($urandom_range(0, 1) == 1) run_len = $urandom_range(thr + 1, thr + 3);
          else run_len = $urandom_range(1, thr + 3);
          for (int i = 0; i < run_len && sent < n_items; i++) begin
            if ($urandom_range(0, 9) == 0) begin
              send_stray();
              sent++;
            end
            send_key(pool_row[pick], pool_col[pick], level);
            sent++;
          end
        end
      endcase
    end
    in_valid <= 1'b0;
    wait_drained();
  endtask

  // Receiver: check each accepted beat, then pick ready for the next edge.
  // A long hold-off request stalls it for a fixed stretch so the block backs up.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) board.check_result(out_row, out_col, key_event);
      if (hold_request && stall_left == 0) begin
        stall_left   = 240;
        hold_request = 1'b0;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(1, 13) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    board = new();
    pool_row[0] = ROW_W'(ROWS - 1);
    pool_col[0] = COL_W'(COLS - 1);
    pool_row[1] = ROW_W'($urandom_range(0, ROWS - 1));
    pool_col[1] = COL_W'($urandom_range(0, COLS - 1));
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed scans at the reset settings (threshold 5, event mode)
    gap_odds   = 3;
    stall_odds = 3;
    send_key('0, '0, 1'b0);                     // untouched key, open: nothing
    repeat (6) send_key('1, '1, 1'b1);          // settles into a press
    send_key('1, '1, 1'b1);                     // counter parked: no repeat
    repeat (6) send_key('1, '1, 1'b0);          // settles into a release
    send_key('0, '1, 1'b1);
    send_key('1, '0, 1'b1);
    send_key(ROW_W'(3), COL_W'(16), 1'b1);      // contact bounce never settles
    send_key(ROW_W'(3), COL_W'(16), 1'b0);
    send_key(ROW_W'(3), COL_W'(16), 1'b1);
    in_valid <= 1'b0;
    wait_drained();

    // Threshold 0: every edge fires at once
    configure(6'd0, 1'b0);
    gap_odds   = 4;
    stall_odds = 4;
    run_phase(60);

    // Switch to report mode keeping all per-key state
    configure(6'd0, 1'b1);
    run_phase(50);

    // Highest threshold in both modes
    configure(6'd63, 1'b1);
    gap_odds   = 8;
    stall_odds = 2;
    run_phase(100);
    configure(6'd63, 1'b0);
    gap_odds   = 2;
    stall_odds = 8;
    run_phase(80);

    // A stretch with no idling on either side
    configure(6'd2, 1'b1);
    gap_odds   = 0;
    stall_odds = 0;
    run_phase(70);

    // Long receiver hold-off while the sender keeps offering scans
    configure(6'd3, 1'b0);
    stall_odds   = 3;
    hold_request = 1'b1;
    run_phase(100);

    // Last part: no idling at all
    configure(6'd1, 1'b1);
    gap_odds   = 0;
    stall_odds = 0;
    run_phase(60);

    // Wait out the pipeline, then count anything still owed as a failure
    for (int w = 0; w < 4000 && board.expected_q.size() != 0; w++) @(posedge clk);
    repeat (10) @(posedge clk);
    board.flush_leftovers();

    $display("tb: %0d key scans checked over %0d register settings", board.checked, settings);
    $display("tb: events seen: %0d press, %0d release, %0d held, %0d none",
             board.ev_counts[int'(EV_PRESS)], board.ev_counts[int'(EV_RELEASE)],
             board.ev_counts[int'(EV_HELD)], board.ev_counts[int'(EV_NONE)]);
    if (board.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin : watchdog
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/kmd_pkg.sv
rtl/kmd_ram.sv
rtl/kmd_update.sv
rtl/key_matrix_debouncer_unit.sv
verif/testbench.sv
